>>> hdl/cfte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfte_pkg: shared types, constants and control store of the CAN text encoder
// Holds the control word layout, the status flags fed back to the sequencer,
// the ASCII codes used on the line and the microprogram itself.
// ----------------------------------------------------------------------------
package cfte_pkg;

	// number of buses served; frames on higher buses are dropped
	localparam int BUS_COUNT = 2;

	// stream widths
	localparam int IN_TDATA_W  = 136;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 8;

	// field widths
	localparam int BUS_W  = 4;
	localparam int TS_W   = 32;
	localparam int ID_W   = 32;
	localparam int DLC_W  = 4;
	localparam int DATA_W = 64;
	localparam int CHAR_W = 7;

	// control store geometry
	localparam int STEP_W = 5;
	localparam int PTR_W  = 5;
	localparam int BCD_DIGITS = 10;

	localparam logic [ID_W-1:0]  ID_MASK_EXT   = 32'h1FFF_FFFF;
	localparam logic [ID_W-1:0]  ID_MASK_STD   = 32'h0000_07FF;
	localparam logic [DLC_W-1:0] MAX_DATA_BYTES = 4'd8;

	// ASCII codes used on the event line
	localparam logic [CHAR_W-1:0] CH_BANG = 7'h21;
	localparam logic [CHAR_W-1:0] CH_C    = 7'h63;
	localparam logic [CHAR_W-1:0] CH_A    = 7'h61;
	localparam logic [CHAR_W-1:0] CH_N    = 7'h6E;
	localparam logic [CHAR_W-1:0] CH_SP   = 7'h20;
	localparam logic [CHAR_W-1:0] CH_DASH = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_X    = 7'h78;
	localparam logic [CHAR_W-1:0] CH_R    = 7'h72;
	localparam logic [CHAR_W-1:0] CH_LF   = 7'h0A;
	localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CH_HEXA = 7'h37;  // 'A' minus ten

	// pointer preloads
	localparam logic [PTR_W-1:0] PTR_CONV = 5'd31;
	localparam logic [PTR_W-1:0] PTR_DEC  = 5'd9;
	localparam logic [PTR_W-1:0] PTR_HEX  = 5'd7;
	localparam logic [PTR_W-1:0] PTR_DATA = 5'd15;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_WAIT,
		OP_CONV,
		OP_CHAR,
		OP_BUSD,
		OP_DASHF,
		OP_FLAGX,
		OP_FLAGR,
		OP_DEC,
		OP_HEX,
		OP_DLCD,
		OP_DATA
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_ACC,
		C_DROP,
		C_PTR_MORE,
		C_NOT_RTR,
		C_DLC_NZ,
		C_DATA_MORE
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
		logic [CHAR_W-1:0] chr;
		logic              ld_ptr;
		logic [PTR_W-1:0]  ptr_val;
		logic              last;
	} ctrl_t;

	typedef struct packed {
		logic accept;
		logic drop;
		logic ptr_more;
		logic rtr;
		logic dlc_nz;
		logic data_more;
		logic stall;
	} status_t;

	// one hex digit as uppercase ASCII
	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
		logic [CHAR_W-1:0] base;
		base = (nib < 4'd10) ? CH_ZERO : CH_HEXA;
		return base + {3'b000, nib};
	endfunction

	function automatic ctrl_t cw(input op_t op, input cond_t cond,
			input logic [STEP_W-1:0] target, input logic [CHAR_W-1:0] chr,
			input logic ld_ptr, input logic [PTR_W-1:0] ptr_val, input logic last);
		ctrl_t w;
		w.op      = op;
		w.cond    = cond;
		w.target  = target;
		w.chr     = chr;
		w.ld_ptr  = ld_ptr;
		w.ptr_val = ptr_val;
		w.last    = last;
		return w;
	endfunction

	// microprogram: one control word per step
	function automatic ctrl_t cfte_rom(input logic [STEP_W-1:0] step);
		ctrl_t w;
		case (step)
			5'd0:  w = cw(OP_WAIT,  C_NO_ACC,    5'd0,  CH_SP,   1'b0, PTR_CONV, 1'b0);
			5'd1:  w = cw(OP_NONE,  C_DROP,      5'd0,  CH_SP,   1'b1, PTR_CONV, 1'b0);
			5'd2:  w = cw(OP_CONV,  C_PTR_MORE,  5'd2,  CH_SP,   1'b0, PTR_CONV, 1'b0);
			5'd3:  w = cw(OP_CHAR,  C_NEXT,      5'd0,  CH_BANG, 1'b0, PTR_CONV, 1'b0);
			5'd4:  w = cw(OP_CHAR,  C_NEXT,      5'd0,  CH_C,    1'b0, PTR_CONV, 1'b0);
			5'd5:  w = cw(OP_CHAR,  C_NEXT,      5'd0,  CH_A,    1'b0, PTR_CONV, 1'b0);
			5'd6:  w = cw(OP_CHAR,  C_NEXT,      5'd0,  CH_N,    1'b0, PTR_CONV, 1'b0);
			5'd7:  w = cw(OP_BUSD,  C_NEXT,      5'd0,  CH_SP,   1'b0, PTR_CONV, 1'b0);
			5'd8:  w = cw(OP_CHAR,  C_NEXT,      5'd0,  CH_SP,   1'b1, PTR_DEC,  1'b0);
			5'd9:  w = cw(OP_DEC,   C_PTR_MORE,  5'd9,  CH_SP,   1'b0, PTR_DEC,  1'b0);
			5'd10: w = cw(OP_CHAR,  C_NEXT,      5'd0,  CH_SP,   1'b0, PTR_DEC,  1'b0);
			5'd11: w = cw(OP_DASHF, C_NEXT,      5'd0,  CH_DASH, 1'b0, PTR_DEC,  1'b0);
			5'd12: w = cw(OP_FLAGX, C_NEXT,      5'd0,  CH_X,    1'b0, PTR_DEC,  1'b0);
			5'd13: w = cw(OP_FLAGR, C_NEXT,      5'd0,  CH_R,    1'b0, PTR_DEC,  1'b0);
			5'd14: w = cw(OP_CHAR,  C_NEXT,      5'd0,  CH_SP,   1'b1, PTR_HEX,  1'b0);
			5'd15: w = cw(OP_HEX,   C_PTR_MORE,  5'd15, CH_SP,   1'b0, PTR_HEX,  1'b0);
			5'd16: w = cw(OP_CHAR,  C_NEXT,      5'd0,  CH_SP,   1'b1, PTR_DATA, 1'b0);
			5'd17: w = cw(OP_NONE,  C_NOT_RTR,   5'd19, CH_SP,   1'b0, PTR_DATA, 1'b0);
			5'd18: w = cw(OP_DLCD,  C_ALWAYS,    5'd22, CH_SP,   1'b0, PTR_DATA, 1'b0);
			5'd19: w = cw(OP_NONE,  C_DLC_NZ,    5'd21, CH_SP,   1'b0, PTR_DATA, 1'b0);
			5'd20: w = cw(OP_CHAR,  C_ALWAYS,    5'd22, CH_DASH, 1'b0, PTR_DATA, 1'b0);
			5'd21: w = cw(OP_DATA,  C_DATA_MORE, 5'd21, CH_SP,   1'b0, PTR_DATA, 1'b0);
			5'd22: w = cw(OP_CHAR,  C_ALWAYS,    5'd0,  CH_LF,   1'b0, PTR_DATA, 1'b1);
			default: w = cw(OP_NONE, C_ALWAYS,   5'd0,  CH_SP,   1'b0, PTR_CONV, 1'b0);
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

>>> hdl/can_frame_text_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// can_frame_text_encoder_core: CAN frame to ASCII event line
// Microcoded encoder that prints one received frame as "!can[B] T F I D\n".
// ----------------------------------------------------------------------------
// One frame is taken at a time and printed at most one character per cycle
// while the output is not held back. Every frame that is not dropped runs
// this step sequence: capture and bus check, the bit-serial timestamp-to-BCD
// converter, then one step per possible character position whether it prints
// or not (four for "!can", one for the bus digit, four separators, ten
// timestamp digits, three flag steps, eight identifier digits), one or two
// decision steps, the data section (the DLC digit, the dash, or two steps
// per data byte) and the LF. A frame on a bus beyond BUS_COUNT is dropped at
// the bus check with no output. The final LF sits in the output register, so
// the next frame is accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module can_frame_text_encoder_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// bus_number[3:0], timestamp_ms[35:4], frame_id[67:36],
	// length_code[71:68], payload[135:72]
	input  wire  [cfte_pkg::IN_TDATA_W-1:0]   s_tdata,
	// extended_id[0], remote_request[1]
	input  wire  [cfte_pkg::IN_TUSER_W-1:0]   s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// out_char[6:0], zero pad[7]
	output logic [cfte_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tlast
);
	import cfte_pkg::*;

	ctrl_t   ctrl;
	status_t st;

	cfte_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctrl   (ctrl)
	);

	cfte_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.st       (st),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	// a taken request moves the sequencer off the wait step
	a_leave_wait: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready right after a request was taken");

	// while waiting for a frame, only a line end may be pending
	a_idle_pending_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tlast)
		else $error("waiting for a frame with a line still in progress");

	// the line end marker travels only on LF
	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == {1'b0, CH_LF})
		else $error("tlast on a character other than LF");
`endif

endmodule
`default_nettype wire

>>> hdl/cfte_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfte_seq: step counter and control store
// Reads one control word per step and picks the next step from the jump
// condition and the datapath status; holds while the datapath stalls.
// ----------------------------------------------------------------------------
module cfte_seq (
	input  wire                clk,
	input  wire                arst_n,
	input  wire cfte_pkg::status_t st,
	output cfte_pkg::ctrl_t    ctrl
);
	import cfte_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              take;

	assign ctrl = cfte_rom(step_q);

	// jump condition
	always_comb begin
		case (ctrl.cond)
			C_NEXT:      take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_ACC:    take = !st.accept;
			C_DROP:      take = st.drop;
			C_PTR_MORE:  take = st.ptr_more;
			C_NOT_RTR:   take = !st.rtr;
			C_DLC_NZ:    take = st.dlc_nz;
			C_DATA_MORE: take = st.data_more;
			default:     take = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (!st.stall) begin
			step_q <= take ? ctrl.target : step_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> hdl/cfte_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfte_dp: frame registers, BCD converter, digit pointer and output register
// Captures a frame, converts the timestamp to BCD one bit per step and picks
// the character of each emitting step into the output register.
// ----------------------------------------------------------------------------
module cfte_dp (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire cfte_pkg::ctrl_t                 ctrl,
	output cfte_pkg::status_t                    st,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [cfte_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  wire  [cfte_pkg::IN_TUSER_W-1:0]      s_tuser,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [cfte_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                 m_tlast
);
	import cfte_pkg::*;

	// captured frame
	logic [BUS_W-1:0]  bus_q;
	logic [TS_W-1:0]   bin_q;
	logic              ext_q;
	logic              rtr_q;
	logic [ID_W-1:0]   id_q;
	logic [DLC_W-1:0]  len_q;
	logic [DATA_W-1:0] data_q;
	logic [3:0]        bcd_q [BCD_DIGITS];

	logic [PTR_W-1:0]  ptr_q;
	logic              lead_q;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	// unpacked input fields
	logic [BUS_W-1:0]  in_bus;
	logic [BUS_W-1:0]  in_bus_eff;
	logic [TS_W-1:0]   in_ts;
	logic [ID_W-1:0]   in_id;
	logic [DLC_W-1:0]  in_dlc;
	logic [DATA_W-1:0] in_data;
	logic              in_ext;
	logic              in_rtr;

	logic              accept;
	logic              emit_req;
	logic              room;
	logic              go;
	logic [CHAR_W-1:0] chr;
	logic [3:0]        dec_dig;
	logic [3:0]        hex_nib;
	logic [3:0]        dat_nib;
	logic [3:0]        idx;
	logic [3:0]        adj [BCD_DIGITS];
	logic              digit_skip;

	assign in_bus  = s_tdata[3:0];
	assign in_ts   = s_tdata[35:4];
	assign in_id   = s_tdata[67:36];
	assign in_dlc  = s_tdata[71:68];
	assign in_data = s_tdata[135:72];
	assign in_ext  = s_tuser[0];
	assign in_rtr  = s_tuser[1];
	assign in_bus_eff = (in_bus == '0) ? BUS_W'(1) : in_bus;

	assign s_tready = (ctrl.op == OP_WAIT);
	assign accept   = s_tvalid && s_tready;

	// digit sources
	assign idx     = ~ptr_q[3:0];
	assign dec_dig = bcd_q[ptr_q[3:0]];
	assign hex_nib = id_q[{ptr_q[2:0], 2'b00} +: 4];
	assign dat_nib = data_q[{idx[3:1], ~idx[0], 2'b00} +: 4];

	// character and emit request per op
	always_comb begin
		chr        = ctrl.chr;
		emit_req   = 1'b0;
		digit_skip = 1'b0;
		case (ctrl.op)
			OP_CHAR:  emit_req = 1'b1;
			OP_BUSD: begin
				emit_req = (bus_q >= BUS_W'(2));
				chr      = CH_ZERO + {3'b000, bus_q};
			end
			OP_DASHF: emit_req = !ext_q && !rtr_q;
			OP_FLAGX: emit_req = ext_q;
			OP_FLAGR: emit_req = rtr_q;
			OP_DEC: begin
				digit_skip = lead_q && (ptr_q != '0) && (dec_dig == 4'd0);
				emit_req   = !digit_skip;
				chr        = CH_ZERO + {3'b000, dec_dig};
			end
			OP_HEX: begin
				digit_skip = lead_q && (ptr_q != '0) && (hex_nib == 4'd0);
				emit_req   = !digit_skip;
				chr        = hex_char(hex_nib);
			end
			OP_DLCD: begin
				emit_req = 1'b1;
				chr      = CH_ZERO + {3'b000, len_q};
			end
			OP_DATA: begin
				emit_req = 1'b1;
				chr      = hex_char(dat_nib);
			end
			default: emit_req = 1'b0;
		endcase
	end

	assign room = !out_valid_q || m_tready;
	assign go   = !(emit_req && !room);

	// status back to the sequencer
	always_comb begin
		st.accept    = accept;
		st.drop      = (bus_q > BUS_W'(BUS_COUNT)) || (bus_q > BUS_W'(9));
		st.ptr_more  = (ptr_q != '0);
		st.rtr       = rtr_q;
		st.dlc_nz    = (len_q != '0);
		st.data_more = ({1'b0, idx} + 5'd1) < {len_q, 1'b0};
		st.stall     = !go;
	end

	// add-3 correction of each BCD digit
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// frame capture and binary-to-BCD shift
	always_ff @(posedge clk) begin
		if (accept) begin
			bus_q  <= in_bus_eff;
			bin_q  <= in_ts;
			ext_q  <= in_ext;
			rtr_q  <= in_rtr;
			id_q   <= in_id & (in_ext ? ID_MASK_EXT : ID_MASK_STD);
			len_q  <= (in_dlc > MAX_DATA_BYTES) ? MAX_DATA_BYTES : in_dlc;
			data_q <= in_data;
			for (int i = 0; i < BCD_DIGITS; i++) begin
				bcd_q[i] <= 4'd0;
			end
		end else if (ctrl.op == OP_CONV) begin
			bin_q    <= {bin_q[TS_W-2:0], 1'b0};
			bcd_q[0] <= {adj[0][2:0], bin_q[TS_W-1]};
			for (int i = 1; i < BCD_DIGITS; i++) begin
				bcd_q[i] <= {adj[i][2:0], adj[i-1][3]};
			end
		end
	end

	// digit pointer and leading-zero flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			lead_q <= 1'b0;
		end else if (go) begin
			if (ctrl.ld_ptr) begin
				ptr_q  <= ctrl.ptr_val;
				lead_q <= 1'b1;
			end else if (ctrl.op == OP_CONV || ctrl.op == OP_DEC ||
					ctrl.op == OP_HEX || ctrl.op == OP_DATA) begin
				ptr_q <= ptr_q - 1'b1;
				if ((ctrl.op == OP_DEC || ctrl.op == OP_HEX) && !digit_skip) begin
					lead_q <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_req && room) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req && room) begin
			out_char_q <= chr;
			out_last_q <= ctrl.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire
